>>> rtl/dbeq_pkg.sv
// ============================================================================
// dbeq_pkg
// Shared types and constants for the debounced button edge queue.
// ============================================================================
package dbeq_pkg;

    localparam int PIN_COUNT = 32;
    localparam int PIN_W     = 5;
    localparam int TIME_W    = 32;
    localparam int LOCK_W    = 16;
    localparam int CNT_W     = 3;
    localparam int IN_W      = 72;
    localparam int OUT_W     = 104;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [31:0] PINS_PRESENT = 32'hffff_ffff >> (32 - PIN_COUNT);

    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 2'd2;

    localparam logic [LOCK_W-1:0] LOCKOUT_RESET     = 16'd4000;
    localparam logic [CNT_W-1:0]  QUEUE_LIMIT_RESET = 3'd4;

    typedef enum logic [1:0] {
        OP_EDGE   = 2'd0,
        OP_POLL   = 2'd1,
        OP_RESYNC = 2'd2
    } opcode_t;

    typedef struct packed {
        logic              accept;
        opcode_t           opcode;
        logic [PIN_W-1:0]  pin_index;
        logic              pin_level;
        logic [TIME_W-1:0] time_us;
        logic [LOCK_W-1:0] lockout_us;
        logic [CNT_W-1:0]  queue_limit;
    } lane_cmd_t;

    typedef struct packed {
        logic hit;
        logic taken;
        logic pending;
    } lane_res_t;

endpackage

>>> rtl/dbeq_lane.sv
// ============================================================================
// dbeq_lane
// Per-pin lane: lockout check, edge acceptance and transition queue count.
// ============================================================================
module dbeq_lane
    import dbeq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [PIN_W-1:0] lane_id,
    input  lane_cmd_t        cmd,
    input  logic             button,
    input  logic             debounced,
    output lane_res_t        res
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] lock_ext;
    logic              sel;
    logic              hit;
    logic              taken;

    assign lock_ext = {{(TIME_W-LOCK_W){1'b0}}, cmd.lockout_us};
    assign elapsed  = cmd.time_us - last_reg;
    assign sel      = cmd.accept && (cmd.opcode == OP_EDGE)
                      && (cmd.pin_index == lane_id);
    assign hit      = sel && button && (elapsed >= lock_ext)
                      && (cmd.pin_level != debounced);
    assign taken    = hit && (count_reg < cmd.queue_limit);

    always_comb
    begin
        count_next = count_reg;
        last_next  = last_reg;
        if (hit)
        begin
            last_next = cmd.time_us;
        end
        if (taken)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        if (cmd.accept && button)
        begin
            case (cmd.opcode)
                OP_POLL:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = CNT_W'(count_reg - 1'b1);
                    end
                end
                OP_RESYNC:
                begin
                    count_next = '0;
                    last_next  = cmd.time_us - lock_ext;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    assign res.hit     = hit;
    assign res.taken   = taken;
    assign res.pending = (count_reg != '0);

endmodule

>>> rtl/dbeq_skid.sv
// ============================================================================
// dbeq_skid
// Two-entry output buffer so the input side keeps moving while a beat waits.
// ============================================================================
module dbeq_skid
    import dbeq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OUT_W-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             push;
    logic             pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= in_data;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_data_reg <= in_data;
            end
            else
            begin
                out_data_reg <= in_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/debounced_button_edge_queue_core.sv
// ============================================================================
// debounced_button_edge_queue_core
// Debounced button edge queue: one lane per pin, merged into the button words.
// ============================================================================
// a result beat is registered in the output buffer, or in its skid entry
// throughput: one beat per cycle while the skid entry is free
// a two-entry output buffer keeps input flowing while one result waits
// reset: queue counts and edge times clear, button words go to all ones,
// registers take their reset values; no clearing pass is needed
module debounced_button_edge_queue_core
    import dbeq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pin_index, pin_level, time_us, raw_levels, zero pad
    input  logic [IN_W-1:0]      s_tdata,
    // opcode
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // current_buttons, previous_buttons, new_presses, edge_taken, zero pad
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [31:0]       button_mask_reg;
    logic [LOCK_W-1:0] lockout_reg;
    logic [CNT_W-1:0]  qlimit_reg;
    logic [31:0]       deb_reg;
    logic [31:0]       deb_next;
    logic [31:0]       now_reg;
    logic [31:0]       now_next;
    logic [31:0]       before_reg;
    logic [31:0]       before_next;

    logic              accept;
    opcode_t           opcode;
    logic [31:0]       raw;
    logic [31:0]       active;
    lane_cmd_t         cmd;
    lane_res_t         lane_res [PIN_COUNT];
    logic [31:0]       hit_vec;
    logic [31:0]       pend_vec;
    logic              taken;
    logic [OUT_W-1:0]  result;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign opcode    = opcode_t'(s_tuser);
    assign raw       = s_tdata[69:38];
    assign active    = button_mask_reg & PINS_PRESENT;

    assign cmd.accept      = accept;
    assign cmd.opcode      = opcode;
    assign cmd.pin_index   = s_tdata[4:0];
    assign cmd.pin_level   = s_tdata[5];
    assign cmd.time_us     = s_tdata[37:6];
    assign cmd.lockout_us  = lockout_reg;
    assign cmd.queue_limit = qlimit_reg;

    for (genvar i = 0; i < PIN_COUNT; i++)
    begin : g_lane
        dbeq_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .lane_id   (PIN_W'(i)),
            .cmd       (cmd),
            .button    (active[i]),
            .debounced (deb_reg[i]),
            .res       (lane_res[i])
        );
    end

    // merge lane findings
    always_comb
    begin
        hit_vec  = '0;
        pend_vec = '0;
        taken    = 1'b0;
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            hit_vec[i]  = lane_res[i].hit;
            pend_vec[i] = lane_res[i].pending;
            taken       = taken | lane_res[i].taken;
        end
    end

    always_comb
    begin
        deb_next    = deb_reg;
        now_next    = now_reg;
        before_next = before_reg;
        if (accept)
        begin
            case (opcode)
                OP_EDGE:
                begin
                    deb_next = deb_reg ^ hit_vec;
                end
                OP_POLL:
                begin
                    before_next = now_reg;
                    now_next    = (now_reg & ~active)
                                  | (active & pend_vec & ~now_reg)
                                  | (active & ~pend_vec & raw);
                end
                OP_RESYNC:
                begin
                    deb_next    = raw;
                    now_next    = raw;
                    before_next = raw;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg    <= '1;
            now_reg    <= '1;
            before_reg <= '1;
        end
        else
        begin
            deb_reg    <= deb_next;
            now_reg    <= now_next;
            before_reg <= before_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_mask_reg <= '0;
            lockout_reg     <= LOCKOUT_RESET;
            qlimit_reg      <= QUEUE_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BUTTON_MASK: button_mask_reg <= cfg_data;
                REG_LOCKOUT:     lockout_reg     <= cfg_data[LOCK_W-1:0];
                REG_QUEUE_LIMIT: qlimit_reg      <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign result = {7'd0, taken, ~now_next & before_next, before_next, now_next};

    dbeq_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

>>> rtl/dbeq_checker.sv
// ============================================================================
// dbeq_checker
// Port-level checks for the debounced button edge queue core.
// ============================================================================
module dbeq_checker
    import dbeq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // new presses match the two button words
    a_press: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[95:64] == (~m_tdata[31:0] & m_tdata[63:32]))
        else $error("new_presses inconsistent");

    // input only stalls while results are buffered
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // beat accepted with the output empty yields a result next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
        else $error("result beat missing");

endmodule

bind debounced_button_edge_queue_core dbeq_checker u_dbeq_checker (.*);

>>> tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the debounced button edge queue core.
// An in-bench predictor tracks the per-pin queues, edge stamps and button
// words. Each accepted input beat queues one predicted result beat, and each
// output beat is checked field by field against the oldest prediction.
// Directed tests cover reset values, lockout and level rules, queue limits,
// time wrap and the unused opcode. A long receiver hold-off fills the core.
// Random phases then run under several register settings, with random
// gaps on both sides.
// ============================================================================
module tb_top;
    import dbeq_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 250;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  pin;
        logic        lvl;
        logic [31:0] t;
        logic [31:0] raw;
    } button_item_t;

    typedef struct packed {
        logic        taken;
        logic [31:0] presses;
        logic [31:0] previous;
        logic [31:0] current;
    } button_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // predictor state
    logic [31:0] btn_mask;
    logic [15:0] lockout;
    logic [2:0]  qlimit;
    logic [2:0]  pend_cnt [PIN_COUNT];
    logic [31:0] edge_stamp [PIN_COUNT];
    logic [31:0] debounced;
    logic [31:0] shown_now;
    logic [31:0] shown_before;

    button_result_t button_results_q [$];
    int          error_count;
    int          cycle_count;
    bit          no_idle;
    int          hold_request;
    int          hold_left;
    int          stall_left;
    logic [31:0] clock_us;

    debounced_button_edge_queue_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic button_item_t mk_item(input logic [1:0] op, input logic [4:0] pin,
                                             input logic lvl, input logic [31:0] t,
                                             input logic [31:0] raw);
        button_item_t it;
        it.op  = op;
        it.pin = pin;
        it.lvl = lvl;
        it.t   = t;
        it.raw = raw;
        return it;
    endfunction

    function automatic button_result_t apply_button_item(input button_item_t it);
        button_result_t res;
        logic [31:0]    next;
        logic [31:0]    since;
        logic [31:0]    seed;
        res = '0;
        case (it.op)
            OP_EDGE:
            begin
                since = it.t - edge_stamp[it.pin];
                if (btn_mask[it.pin] && since >= {16'd0, lockout}
                    && it.lvl != debounced[it.pin])
                begin
                    edge_stamp[it.pin] = it.t;
                    debounced[it.pin]  = ~debounced[it.pin];
                    if (pend_cnt[it.pin] < qlimit)
                    begin
                        pend_cnt[it.pin] = pend_cnt[it.pin] + 3'd1;
                        res.taken = 1'b1;
                    end
                end
            end
            OP_POLL:
            begin
                next = shown_now;
                for (int i = 0; i < PIN_COUNT; i++)
                begin
                    if (btn_mask[i])
                    begin
                        if (pend_cnt[i] != 3'd0)
                        begin
                            pend_cnt[i] = pend_cnt[i] - 3'd1;
                            next[i] = ~next[i];
                        end
                        else
                            next[i] = it.raw[i];
                    end
                end
                shown_before = shown_now;
                shown_now    = next;
            end
            OP_RESYNC:
            begin
                seed = it.t - {16'd0, lockout};
                debounced = it.raw;
                for (int i = 0; i < PIN_COUNT; i++)
                begin
                    if (btn_mask[i])
                    begin
                        pend_cnt[i]   = 3'd0;
                        edge_stamp[i] = seed;
                    end
                end
                shown_now    = it.raw;
                shown_before = it.raw;
            end
            default: ;
        endcase
        res.current  = shown_now;
        res.previous = shown_before;
        res.presses  = ~shown_now & shown_before;
        return res;
    endfunction

    // called at a falling edge, returns at a falling edge with s_tvalid still high
    task automatic send_item(input button_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.op;
        s_tdata  = {2'b00, it.raw, it.t, it.lvl, it.pin};
        do
            @(posedge clk);
        while (!s_tready);
        button_results_q.push_back(apply_button_item(it));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (button_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_BUTTON_MASK: btn_mask = value;
            REG_LOCKOUT:     lockout  = value[15:0];
            REG_QUEUE_LIMIT: qlimit   = value[2:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // upper bits of the narrow registers carry junk that must be ignored
    task automatic set_regs(input logic [31:0] mask, input logic [15:0] lock,
                            input logic [2:0] qlim);
        wait_idle();
        write_reg(REG_BUTTON_MASK, mask);
        write_reg(REG_LOCKOUT, {16'($urandom), lock});
        write_reg(REG_QUEUE_LIMIT, {29'($urandom), qlim});
        cfg_valid = 1'b0;
    endtask

    task automatic test_reset_values();
        send_item(mk_item(OP_POLL, 5'd3, 1'b0, 32'd100, $urandom));
        send_item(mk_item(OP_EDGE, 5'd3, 1'b0, 32'd9000, $urandom));
        send_item(mk_item(OP_UNUSED, 5'd31, 1'b1, $urandom, $urandom));
    endtask

    task automatic test_edge_rules();
        set_regs(32'hffff_ff7f, 16'd4000, 3'd4);
        send_item(mk_item(OP_RESYNC, 5'd0, 1'b0, 32'h1000, 32'hffff_ffff));
        send_item(mk_item(OP_EDGE, 5'd0, 1'b0, 32'h1000, '0));
        send_item(mk_item(OP_EDGE, 5'd0, 1'b1, 32'h1000 + 32'd3999, '0));
        send_item(mk_item(OP_EDGE, 5'd0, 1'b0, 32'h1000 + 32'd8000, '0));
        send_item(mk_item(OP_EDGE, 5'd0, 1'b1, 32'h1000 + 32'd8000, '0));
        send_item(mk_item(OP_EDGE, 5'd7, 1'b0, 32'h1000 + 32'd8500, '0));
        send_item(mk_item(OP_EDGE, 5'd31, 1'b0, 32'h1000 + 32'd9000, '0));
        send_item(mk_item(OP_POLL, 5'd0, 1'b0, 32'h4000, 32'hffff_ffff));
        send_item(mk_item(OP_POLL, 5'd0, 1'b0, 32'h5000, 32'h0000_0000));
        send_item(mk_item(OP_POLL, 5'd0, 1'b0, 32'h6000, 32'hffff_ffff));
    endtask

    task automatic test_queue_limits();
        set_regs(32'hffff_ffff, 16'd0, 3'd1);
        send_item(mk_item(OP_EDGE, 5'd5, 1'b0, 32'd10, '0));
        send_item(mk_item(OP_EDGE, 5'd5, 1'b1, 32'd10, '0));
        send_item(mk_item(OP_POLL, 5'd0, 1'b0, 32'd20, 32'hffff_ffff));
        set_regs(32'hffff_ffff, 16'd0, 3'd0);
        send_item(mk_item(OP_EDGE, 5'd3, 1'b0, 32'd30, '0));
        send_item(mk_item(OP_POLL, 5'd0, 1'b0, 32'd40, 32'hffff_fff7));
        set_regs(32'hffff_ffff, 16'hffff, 3'd7);
        send_item(mk_item(OP_RESYNC, 5'd0, 1'b0, 32'd5, 32'hffff_ffff));
        for (int k = 0; k < 8; k++)
            send_item(mk_item(OP_EDGE, 5'd9, k[0], 32'd5 + 32'hffff * (k + 1), '0));
        send_item(mk_item(OP_POLL, 5'd0, 1'b0, 32'h0010_0000, 32'hffff_ffff));
    endtask

    task automatic test_wrap_and_unused();
        set_regs(32'h0000_00ff, 16'd100, 3'd3);
        send_item(mk_item(OP_RESYNC, 5'd0, 1'b0, 32'hffff_ffc0, 32'h5a5a_ffff));
        send_item(mk_item(OP_EDGE, 5'd1, 1'b0, 32'h0000_0010, '0));
        send_item(mk_item(OP_EDGE, 5'd1, 1'b0, 32'h0000_0024, '0));
        send_item(mk_item(OP_UNUSED, 5'd1, 1'b1, 32'hffff_ffff, 32'hffff_ffff));
        send_item(mk_item(OP_POLL, 5'd0, 1'b0, 32'h0000_0100, 32'h0000_0000));
    endtask

    task automatic test_backpressure();
        set_regs(32'hffff_ffff, 16'd0, 3'd7);
        no_idle = 1'b1;
        hold_request = 300;
        for (int k = 0; k < 16; k++)
            send_item(mk_item(k[0] ? OP_POLL : OP_EDGE, 5'($urandom), 1'($urandom),
                              $urandom, $urandom));
        no_idle = 1'b0;
    endtask

    function automatic button_item_t make_random_item();
        button_item_t it;
        int           r;
        logic [4:0]   pin;
        r   = $urandom_range(0, 99);
        pin = 5'($urandom);
        it  = mk_item(OP_EDGE, pin, 1'($urandom), $urandom, $urandom);
        if (r < 45)
        begin
            if (btn_mask != 0)
                while (!btn_mask[pin])
                    pin = 5'($urandom);
            it.pin = pin;
            it.lvl = ($urandom_range(0, 9) < 8) ? ~debounced[pin] : debounced[pin];
            if ($urandom_range(0, 9) < 7)
                clock_us = clock_us + lockout + $urandom_range(0, 3000);
            else
                clock_us = clock_us + $urandom_range(0, lockout);
            it.t = clock_us;
        end
        else if (r < 75)
        begin
            clock_us = clock_us + $urandom_range(0, 20000);
            it.op  = OP_POLL;
            it.t   = clock_us;
            it.raw = debounced ^ ($urandom & $urandom & $urandom);
        end
        else if (r < 80)
        begin
            clock_us = clock_us + $urandom_range(0, 100);
            it.op = OP_RESYNC;
            it.t  = clock_us;
        end
        else if (r < 85)
            it.op = OP_UNUSED;
        else if (r < 90)
            it.op = 2'($urandom);
        return it;
    endfunction

    task automatic test_random_traffic();
        logic [31:0] mask;
        logic [15:0] lock;
        logic [2:0]  qlim;
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: begin mask = 32'hffff_ffff; lock = 16'd0;     qlim = 3'd7; end
                1: begin mask = $urandom;      lock = 16'd4000;  qlim = 3'd4; end
                2: begin mask = 32'h8000_0001; lock = 16'hffff;  qlim = 3'd1; end
                3: begin mask = $urandom;      lock = 16'($urandom); qlim = 3'd2; end
                4: begin mask = 32'h0000_0000; lock = 16'd1;     qlim = 3'd3; end
                5: begin mask = ~32'h0 ^ (32'b1 << $urandom_range(0, 31));
                         lock = 16'($urandom_range(0, 500)); qlim = 3'd6; end
                6: begin mask = $urandom & $urandom; lock = 16'd2000; qlim = 3'd0; end
                default: begin mask = $urandom; lock = 16'($urandom);
                               qlim = 3'($urandom_range(1, 7)); end
            endcase
            set_regs(mask, lock, qlim);
            no_idle  = (ph == 3);
            clock_us = (ph == 2) ? 32'hfff0_0000 : $urandom;
            send_item(mk_item(OP_RESYNC, 5'd0, 1'b0, clock_us, $urandom));
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_item(make_random_item());
            no_idle = 1'b0;
        end
    endtask

    // receiver side
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end
        else if (no_idle)
            m_tready = 1'b1;
        else if (stall_left > 0)
        begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            m_tready   = 1'b1;
            stall_left = pick_gap();
        end
    end

    // result beat check
    always @(posedge clk)
    begin
        button_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (button_results_q.size() == 0)
            begin
                $display("%0t: result beat with none expected, actual %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = button_results_q.pop_front();
                if (m_tdata[31:0] !== want.current)
                begin
                    $display("%0t: current_buttons expected %h actual %h",
                             $time, want.current, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[63:32] !== want.previous)
                begin
                    $display("%0t: previous_buttons expected %h actual %h",
                             $time, want.previous, m_tdata[63:32]);
                    error_count++;
                end
                if (m_tdata[95:64] !== want.presses)
                begin
                    $display("%0t: new_presses expected %h actual %h",
                             $time, want.presses, m_tdata[95:64]);
                    error_count++;
                end
                if (m_tdata[96] !== want.taken)
                begin
                    $display("%0t: edge_taken expected %b actual %b",
                             $time, want.taken, m_tdata[96]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, button_results_q.size());
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        error_count  = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        hold_request = 0;
        hold_left    = 0;
        stall_left   = 0;
        clock_us     = '0;
        btn_mask     = '0;
        lockout      = LOCKOUT_RESET;
        qlimit       = QUEUE_LIMIT_RESET;
        debounced    = '1;
        shown_now    = '1;
        shown_before = '1;
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            pend_cnt[i]   = '0;
            edge_stamp[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_edge_rules();
        test_queue_limits();
        test_wrap_and_unused();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
